// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge of aclk outside reset.
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(name, expr, msg) `ASSERT_CLK(name, !(expr), msg)

`endif

// ===== src/wpbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Window parity bit packer package
// Shared widths, constants and the structs passed between the modules.
// ----------------------------------------------------------------------------
package wpbp_pkg;

    // Field and datapath widths.
    localparam int TS_W    = 30;
    localparam int WL_W    = 16;
    localparam int IDX_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int BITS_W  = 4;
    localparam int FILL_W  = 3;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Window length after reset.
    localparam logic [WL_W-1:0] WL_RESET = 16'd128;

    // Item kinds carried on tuser of the input channel.
    localparam logic MODE_EVENT = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // Bit count of a complete output byte.
    localparam logic [BITS_W-1:0] BITS_FULL = 4'd8;

    // Classified input item.
    typedef struct packed {
        logic            flush;
        logic [TS_W-1:0] timestamp;
    } cmd_t;

    // Divider request and response.
    typedef struct packed {
        logic             start;
        logic [IDX_W-1:0] dividend;
        logic [WL_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [IDX_W-1:0] quotient;
        logic [WL_W-1:0]  remainder;
    } div_rsp_t;

    // One result item.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [BITS_W-1:0] bits_in_byte;
        logic              last;
        logic              gap_clipped;
    } res_t;

endpackage

// ===== src/wpbp_queue.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module wpbp_queue import wpbp_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = q_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== src/wpbp_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring divider producing a 32-bit quotient, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wpbp_div import wpbp_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int STEP_W = $clog2(IDX_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  quo_reg, quo_next;
    logic [WL_W-1:0]   rem_reg, rem_next;
    logic [WL_W-1:0]   dvs_reg, dvs_next;
    logic [WL_W:0]     shifted;
    logic [WL_W:0]     trial;
    logic              q_bit;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {rem_reg, quo_reg[IDX_W-1]};
    assign q_bit   = (shifted >= {1'b0, dvs_reg});
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next  = q_bit ? trial[WL_W-1:0] : shifted[WL_W-1:0];
            quo_next  = {quo_reg[IDX_W-2:0], q_bit};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(IDX_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

// ===== src/wpbp_back.sv =====
// ----------------------------------------------------------------------------
// Packer back end
// Window state, gap sizing, bit packing and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wpbp_back import wpbp_pkg::*; #(
    parameter int MAX_OUT_BYTES = 64
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  cmd_t            cmd,
    output logic            cmd_pop,
    input  logic [WL_W-1:0] divisor,
    output div_req_t        div_req,
    input  div_rsp_t        div_rsp,
    input  logic            m_tready,
    output logic            m_valid,
    output res_t            m_res
);

    localparam int ZCAP  = 8 * (MAX_OUT_BYTES - 1);
    localparam int TOT_W = $clog2(8 * MAX_OUT_BYTES + 1);
    localparam int CNT_W = TOT_W - 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_GAP  = 3'd2;
    localparam logic [2:0] S_PACK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              started_reg, started_next;
    logic              parity_reg, parity_next;
    logic [TS_W-1:0]   base_reg, base_next;
    logic [IDX_W-1:0]  cw_reg, cw_next;
    logic [BYTE_W-1:0] buf_reg, buf_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [TS_W-1:0]   ts_reg, ts_next;
    logic [TOT_W-1:0]  zeros_reg, zeros_next;
    logic              clip_reg, clip_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] obyte_reg, obyte_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_res_reg, m_res_next;

    logic              slot_free;
    logic [IDX_W-1:0]  diff;
    logic              gap_pos;
    logic              gap_clip;
    logic [IDX_W-1:0]  zeros_raw;
    logic [TOT_W-1:0]  total;
    logic [BYTE_W-1:0] head;

    assign slot_free = !m_valid_reg || m_tready;

    // Gap between the new window index and the open window.
    assign diff      = div_rsp.quotient - cw_reg;
    assign gap_pos   = (diff > 32'd1) && !diff[IDX_W-1];
    assign gap_clip  = gap_pos && (diff > IDX_W'(ZCAP + 1));
    assign zeros_raw = diff - 1'b1;

    // Bits pending after the parity and the zero fill go in.
    assign total = TOT_W'(fill_reg) + TOT_W'(1) + zeros_reg;
    assign head  = {buf_reg[BYTE_W-2:0], parity_reg};

    always_comb begin
        state_next   = state_reg;
        started_next = started_reg;
        parity_next  = parity_reg;
        base_next    = base_reg;
        cw_next      = cw_reg;
        buf_next     = buf_reg;
        fill_next    = fill_reg;
        ts_next      = ts_reg;
        zeros_next   = zeros_reg;
        clip_next    = clip_reg;
        cnt_next     = cnt_reg;
        obyte_next   = obyte_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_res_next   = m_res_reg;
        cmd_pop      = 1'b0;
        div_req.start    = 1'b0;
        div_req.divisor  = divisor;
        div_req.dividend = started_reg ? ({2'b00, cmd.timestamp} - {2'b00, base_reg})
                                       : {2'b00, cmd.timestamp};

        case (state_reg)
            // Take the next item: a flush finishes here, an event starts a division.
            S_IDLE: begin
                if (cmd_valid) begin
                    if (cmd.flush) begin
                        if (slot_free) begin
                            cmd_pop = 1'b1;
                            if (fill_reg != '0) begin
                                m_valid_next            = 1'b1;
                                m_res_next.out_byte     = buf_reg;
                                m_res_next.bits_in_byte = BITS_W'(fill_reg);
                                m_res_next.last         = 1'b1;
                                m_res_next.gap_clipped  = 1'b0;
                            end
                            started_next = 1'b0;
                            parity_next  = 1'b0;
                            base_next    = '0;
                            cw_next      = '0;
                            buf_next     = '0;
                            fill_next    = '0;
                        end
                    end else begin
                        cmd_pop       = 1'b1;
                        ts_next       = cmd.timestamp;
                        div_req.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end

            // Wait for the quotient; the first event of a stream only sets the base.
            S_DIV: begin
                if (div_rsp.done) begin
                    if (!started_reg) begin
                        base_next    = ts_reg - TS_W'(div_rsp.remainder);
                        cw_next      = '0;
                        started_next = 1'b1;
                        parity_next  = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_GAP;
                    end
                end
            end

            // Same window toggles the parity, a new one sizes the zero fill.
            S_GAP: begin
                if (div_rsp.quotient == cw_reg) begin
                    parity_next = !parity_reg;
                    state_next  = S_IDLE;
                end else begin
                    zeros_next = !gap_pos ? '0 :
                                 gap_clip ? TOT_W'(ZCAP) : zeros_raw[TOT_W-1:0];
                    clip_next  = gap_clip;
                    state_next = S_PACK;
                end
            end

            // Pack the parity and zeros; only the first full byte carries data.
            S_PACK: begin
                cnt_next    = total[TOT_W-1:3];
                fill_next   = total[FILL_W-1:0];
                obyte_next  = head << (3'd7 - fill_reg);
                buf_next    = (total[TOT_W-1:3] == '0) ? (head << zeros_reg[FILL_W-1:0]) : '0;
                parity_next = 1'b1;
                cw_next     = div_rsp.quotient;
                state_next  = (total[TOT_W-1:3] == '0) ? S_IDLE : S_EMIT;
            end

            // Hand out the full bytes one per free output slot.
            S_EMIT: begin
                if (slot_free) begin
                    m_valid_next            = 1'b1;
                    m_res_next.out_byte     = obyte_reg;
                    m_res_next.bits_in_byte = BITS_FULL;
                    m_res_next.last         = (cnt_reg == CNT_W'(1));
                    m_res_next.gap_clipped  = clip_reg;
                    obyte_next              = '0;
                    cnt_next                = cnt_reg - 1'b1;
                    if (cnt_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and stream state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            started_reg <= 1'b0;
            parity_reg  <= 1'b0;
            base_reg    <= '0;
            cw_reg      <= '0;
            buf_reg     <= '0;
            fill_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            started_reg <= started_next;
            parity_reg  <= parity_next;
            base_reg    <= base_next;
            cw_reg      <= cw_next;
            buf_reg     <= buf_next;
            fill_reg    <= fill_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        ts_reg    <= ts_next;
        zeros_reg <= zeros_next;
        clip_reg  <= clip_next;
        obyte_reg <= obyte_next;
        m_res_reg <= m_res_next;
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // Checks on the sequencing.
    `ASSERT_CLK(a_done_in_div, div_rsp.done |-> state_reg == S_DIV, "divider done outside wait")
    `ASSERT_CLK(a_flush_clears, (cmd_pop && cmd.flush) |=> (!started_reg && fill_reg == '0), "flush left stream state")
    `ASSERT_NEVER(a_emit_count, state_reg == S_EMIT && cnt_reg == '0, "emit with no bytes left")
    `ASSERT_CLK(a_partial_last, (m_valid_reg && m_res_reg.bits_in_byte != BITS_FULL) |-> (m_res_reg.last && !m_res_reg.gap_clipped), "partial byte not final")

endmodule

// ===== src/window_parity_bit_packer_top.sv =====
// Event path: the input queue, the iterative divider, then the wait, gap and pack steps; an
// event's first byte is registered in the output register, and later bytes follow one per
// cycle while the output is not stalled. A flush passes the queue and the output register.
// The back end handles one item at a time while the queue holds up to two waiting items, and
// every event goes through the single iterative divider.
// Stalls on the output hold flushes and byte emission. Reset: aresetn clears state.
// ----------------------------------------------------------------------------
// Window parity bit packer, top level
// Assigns timestamps to windows and packs one parity bit per window into bytes.
// Synchronous active-low aresetn clears the stream state, sets window_length to
// 128 and empties the queue; there is no clearing pass.
// ----------------------------------------------------------------------------
module window_parity_bit_packer_top import wpbp_pkg::*; #(
    parameter int MAX_OUT_BYTES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,      // window_length
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [29:0] timestamp, [31:30] zero
    input  logic        s_axis_tuser,  // [0] mode
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [11:8] bits_in_byte, [15:12] zero
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // [0] gap_clipped
);

    logic [WL_W-1:0] wl_reg, wl_next;
    logic [WL_W-1:0] divisor;
    cmd_t            in_cmd;
    cmd_t            q_cmd;
    logic            q_valid;
    logic            q_pop;
    div_req_t        div_req;
    div_rsp_t        div_rsp;
    res_t            res;

    // Window length register; always ready.
    assign cfg_ready = 1'b1;
    assign wl_next   = (cfg_valid && cfg_ready) ? cfg_data : wl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg <= WL_RESET;
        end else begin
            wl_reg <= wl_next;
        end
    end

    // A zero length counts as one tick.
    assign divisor = (wl_reg == '0) ? WL_W'(1) : wl_reg;

    // Front: classify each incoming transaction.
    assign in_cmd.flush     = (s_axis_tuser == MODE_FLUSH);
    assign in_cmd.timestamp = s_axis_tdata[TS_W-1:0];

    wpbp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_axis_tvalid),
        .push_ready (s_axis_tready),
        .push_cmd   (in_cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_pop),
        .pop_cmd    (q_cmd)
    );

    wpbp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    wpbp_back #(
        .MAX_OUT_BYTES (MAX_OUT_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .divisor   (divisor),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tready  (m_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_res     (res)
    );

    // Result packing.
    assign m_axis_tdata = {4'b0000, res.bits_in_byte, res.out_byte};
    assign m_axis_tlast = res.last;
    assign m_axis_tuser = res.gap_clipped;

endmodule

// ===== dv/window_parity_bit_packer_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Window parity bit packer testbench
// Drives timestamp and flush transactions into the packer, predicts the
// packed bytes from a behavioral model of the windowing and packing rules
// or from table entries, and compares each result field by field. A short
// directed table, with one long output stall, covers the corner cases. One
// random phase per window length follows, idling both streams at random.
// ----------------------------------------------------------------------------
module window_parity_bit_packer_top_tb;
    import wpbp_pkg::*;

    localparam int MAX_OUT_BYTES = 64;
    localparam int GAP_CAP       = 8 * (MAX_OUT_BYTES - 1);
    localparam int SETTLE        = 100;
    localparam int PHASE_ITEMS   = 33;
    localparam int NUM_PHASES    = 6;
    localparam int PLAN_ROWS     = 25;
    localparam int SQUEEZE_LEN   = 400;

    // How the expected results of one stimulus row are obtained.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } chk_e;

    typedef struct packed {
        logic              mode;
        logic [TS_W-1:0]   ts;
        chk_e              chk;
        logic [BYTE_W-1:0] exp_byte;
        logic [BITS_W-1:0] exp_bits;
        logic              exp_clip;
    } step_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data      = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        m_axis_tuser;

    // Predicted packer state.
    logic [WL_W-1:0]  win_len;
    logic [31:0]      win_base;
    logic [31:0]      cur_win;
    logic             in_stream;
    logic             win_parity;
    logic [7:0]       acc_byte;
    int               acc_fill;

    res_t item_bytes[$];
    res_t expected_bytes[$];
    int   mismatches  = 0;
    bit   quiet       = 1'b0;
    bit   squeeze_req = 1'b0;

    // Directed table, walked with the reset window length of 128 ticks.
    step_t plan [0:PLAN_ROWS-1] = '{
        // First event sets the base, then two more in windows 0 and 1.
        '{MODE_EVENT, 30'd0,          CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd127,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd128,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        // Jump to window 10: parity 1 and eight skipped windows.
        '{MODE_EVENT, 30'd1280,       CHK_ONE,   8'h40, 4'd8, 1'b0},
        '{MODE_FLUSH, 30'd0,          CHK_ONE,   8'h00, 4'd2, 1'b0},
        // Largest decimal timestamp, then a much earlier one that wraps
        // to a huge positive index and saturates the zero fill.
        '{MODE_EVENT, 30'd999999999,  CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd0,          CHK_MODEL, 8'h00, 4'd0, 1'b0},
        '{MODE_FLUSH, 30'd0,          CHK_ONE,   8'h00, 4'd1, 1'b0},
        // Timestamp with all bits set, then a flush with nothing packed.
        '{MODE_EVENT, 30'h3FFFFFFF,   CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_FLUSH, 30'h3FFFFFFF,   CHK_NONE,  8'h00, 4'd0, 1'b0},
        // Base 4992; forward to window 10, back to window 4, on to 5.
        '{MODE_EVENT, 30'd5000,       CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd6272,       CHK_ONE,   8'h80, 4'd8, 1'b0},
        '{MODE_EVENT, 30'd5504,       CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd5632,       CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_FLUSH, 30'd0,          CHK_ONE,   8'h03, 4'd4, 1'b0},
        // One event per window for nine windows gives an all-ones byte.
        '{MODE_EVENT, 30'd0,          CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd128,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd256,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd384,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd512,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd640,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd768,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd896,        CHK_NONE,  8'h00, 4'd0, 1'b0},
        '{MODE_EVENT, 30'd1024,       CHK_ONE,   8'hFF, 4'd8, 1'b0},
        '{MODE_FLUSH, 30'd0,          CHK_NONE,  8'h00, 4'd0, 1'b0}
    };

    window_parity_bit_packer_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    // Clear the stream state, as after reset or a flush.
    function automatic void restart_stream();
        win_base   = '0;
        cur_win    = '0;
        in_stream  = 1'b0;
        win_parity = 1'b0;
        acc_byte   = '0;
        acc_fill   = 0;
    endfunction

    // Shift one bit into the byte accumulator and emit it once full.
    function automatic void shift_in(logic b, logic clip);
        res_t r;
        acc_byte = {acc_byte[6:0], b};
        acc_fill++;
        if (acc_fill == 8) begin
            r.out_byte     = acc_byte;
            r.bits_in_byte = BITS_FULL;
            r.last         = 1'b0;
            r.gap_clipped  = clip;
            item_bytes.push_back(r);
            acc_byte = '0;
            acc_fill = 0;
        end
    endfunction

    // Work out the bytes that one accepted transaction produces.
    function automatic void pack_window_bits(logic mode, logic [TS_W-1:0] ts);
        logic [31:0] len;
        logic [31:0] stamp;
        logic [31:0] idx;
        logic [31:0] diff;
        logic [31:0] zeros;
        logic        clip;
        res_t        r;
        item_bytes.delete();
        len   = (win_len == '0) ? 32'd1 : {16'd0, win_len};
        stamp = {2'b00, ts};
        if (mode == MODE_FLUSH) begin
            if (acc_fill != 0) begin
                r.out_byte     = acc_byte;
                r.bits_in_byte = acc_fill[BITS_W-1:0];
                r.last         = 1'b0;
                r.gap_clipped  = 1'b0;
                item_bytes.push_back(r);
            end
            restart_stream();
        end else begin
            if (!in_stream)
                win_base = (stamp / len) * len;
            idx = (stamp - win_base) / len;
            if (!in_stream) begin
                in_stream  = 1'b1;
                cur_win    = idx;
                win_parity = 1'b1;
            end else if (idx == cur_win) begin
                win_parity = ~win_parity;
            end else begin
                // Skipped windows only count when the index moved forward.
                diff  = idx - cur_win;
                zeros = (diff > 32'd1 && diff < 32'h8000_0000) ? diff - 32'd1 : 32'd0;
                clip  = (zeros > GAP_CAP);
                if (clip)
                    zeros = GAP_CAP;
                shift_in(win_parity, clip);
                for (int k = 0; k < zeros; k++)
                    shift_in(1'b0, clip);
                win_parity = 1'b1;
                cur_win    = idx;
            end
        end
    endfunction

    // Offer one transaction and queue its expected results once taken.
    task automatic offer(input step_t row);
        res_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, row.ts};
        s_axis_tuser  <= row.mode;
        do @(posedge aclk); while (!s_axis_tready);
        pack_window_bits(row.mode, row.ts);
        if (row.chk == CHK_MODEL) begin
            foreach (item_bytes[i]) begin
                r      = item_bytes[i];
                r.last = (i == item_bytes.size() - 1);
                expected_bytes.push_back(r);
            end
        end else if (row.chk == CHK_ONE) begin
            r.out_byte     = row.exp_byte;
            r.bits_in_byte = row.exp_bits;
            r.last         = 1'b1;
            r.gap_clipped  = row.exp_clip;
            expected_bytes.push_back(r);
        end
    endtask

    // Random pause on the input side.
    task automatic idle_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    // Wait until every expected byte has arrived and the block is quiet.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_len(input logic [WL_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        win_len = len;
    endtask

    function automatic void flag_field(string name, int want, int got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    endfunction

    // Result side: check every transaction and stall at random.
    initial begin : result_sink
        int   hold;
        bit   squeezed;
        res_t got;
        res_t want;
        hold     = 0;
        squeezed = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid && m_axis_tready) begin
                got.out_byte     = m_axis_tdata[7:0];
                got.bits_in_byte = m_axis_tdata[11:8];
                got.last         = m_axis_tlast;
                got.gap_clipped  = m_axis_tuser;
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, got);
                end else begin
                    want = expected_bytes.pop_front();
                    if (got.out_byte !== want.out_byte)
                        flag_field("out_byte", want.out_byte, got.out_byte);
                    if (got.bits_in_byte !== want.bits_in_byte)
                        flag_field("bits_in_byte", want.bits_in_byte, got.bits_in_byte);
                    if (got.last !== want.last)
                        flag_field("last", want.last, got.last);
                    if (got.gap_clipped !== want.gap_clipped)
                        flag_field("gap_clipped", want.gap_clipped, got.gap_clipped);
                end
            end
            // One long hold-off so that the block backs up into its input.
            if (squeeze_req && !squeezed) begin
                hold     = SQUEEZE_LEN;
                squeezed = 1'b1;
            end else if (hold == 0 && !quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 10);
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Stimulus: reset, directed table, then one random phase per window length.
    initial begin : stimulus
        logic [WL_W-1:0] lens [NUM_PHASES];
        logic [31:0]     prev;
        logic [31:0]     nxt;
        step_t           row;
        int              pick;
        int              eff;
        win_len = WL_RESET;
        restart_stream();
        lens[0] = 16'd0;
        lens[1] = 16'd1;
        lens[2] = 16'hFFFF;
        lens[3] = 16'($urandom_range(2, 40));
        lens[4] = 16'($urandom_range(41, 65534));
        lens[5] = WL_RESET;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < PLAN_ROWS; i++) begin
            // Stall the output while the saturated gap is being packed.
            if (i == 6)
                squeeze_req = 1'b1;
            offer(plan[i]);
            idle_gap();
        end
        wait_idle();

        prev = '0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            write_len(lens[p]);
            eff = (win_len == '0) ? 1 : int'(win_len);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Mostly runs of nearby timestamps, with noise, jumps back,
                // long gaps and flushes mixed in.
                row      = '{MODE_EVENT, 30'd0, CHK_MODEL, 8'h00, 4'd0, 1'b0};
                pick     = $urandom_range(0, 99);
                if (pick < 8) begin
                    row.mode = MODE_FLUSH;
                    nxt      = $urandom;
                end else if (pick < 16) begin
                    nxt = $urandom;
                end else if (pick < 20) begin
                    nxt = prev - $urandom_range(0, 8 * eff);
                end else if (pick < 23) begin
                    nxt = prev + eff * $urandom_range(500, 700);
                end else if (pick < 35) begin
                    nxt = prev + eff * $urandom_range(2, 20) + $urandom_range(0, eff - 1);
                end else begin
                    nxt = prev + $urandom_range(0, eff);
                end
                row.ts = nxt[TS_W-1:0];
                if (row.mode == MODE_EVENT)
                    prev = {2'b00, row.ts};
                offer(row);
                idle_gap();
            end
            wait_idle();
        end

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog.
    initial begin
        #12_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
